// ===== src/rfc_pkg.sv =====
// Shared types, constants and the digest step for the radio frame checker.
// Depends on nothing; every other file of the block but rfc_if.sv imports it.
`timescale 1ns / 1ps

package rfc_pkg;

    // Result status codes, in order of precedence after a short frame.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_LONG    = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_VERSION = 3'd4,
        ST_NETWORK = 3'd5,
        ST_LENGTH  = 3'd6
    } status_t;

    localparam int unsigned HeaderLen = 17;

    localparam logic [7:0] MagicByte0   = 8'h44;
    localparam logic [7:0] MagicByte1   = 8'h53;
    localparam logic [7:0] VersionByte  = 8'h03;

    localparam logic [31:0] FnvBasis = 32'd2166136261;

    // One FNV-1a step. The prime 0x01000193 is applied as a sum of shifts:
    // x * (2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1).
    function automatic logic [31:0] fnv_mix(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = acc ^ {24'd0, b};
            fnv_mix = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

// ===== src/rfc_if.sv =====
// Handshake channels of the radio frame checker: received bytes, results and
// the configuration write. Plain valid/ready interfaces, no package needed.
`timescale 1ns / 1ps

interface rfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

interface rfc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [31:0] session_id;
    logic [31:0] sequence_no;
    logic [6:0]  payload_bytes;
    logic [31:0] frame_digest;

    modport source (output valid, output status, output frame_type, output session_id,
                    output sequence_no, output payload_bytes, output frame_digest,
                    input ready);
    modport sink   (input valid, input status, input frame_type, input session_id,
                    input sequence_no, input payload_bytes, input frame_digest,
                    output ready);
endinterface

interface rfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/radio_frame_checker_with_digest.sv =====
// Top level of the radio frame checker with payload digest.
// Depends on rfc_pkg and the channel interfaces in rfc_if.sv.
`timescale 1ns / 1ps

// The block takes a received frame one byte per item, header first, with the
// final byte marked by last. It checks the 17-byte header (magic 0x44 0x53,
// version 3, big-endian network id in bytes 4 to 7 against the configured
// expected_network), captures type, session, sequence and the declared payload
// length, and folds the type byte and every payload byte into an FNV-1a 32-bit
// digest. The item carrying last produces exactly one result; every other item
// produces none. A failed frame reports the first failure (too short, too long,
// bad magic, bad version, wrong network, length mismatch, in that order) with
// all other result fields zero. Bytes beyond the header plus MAX_PAYLOAD make
// the frame too long and are otherwise ignored. Throughput is one byte per
// clock cycle: an accepted byte sits in an input register, and the frame state
// and digest are then updated from it; the digest step is a shift-and-add
// multiply by the FNV prime. A result is loaded into an output register as
// its last byte leaves the input register and is held there, so the next
// frame keeps streaming while the result waits; input ready only drops when a
// last byte is waiting behind an untaken result. The configuration register may
// be written at any time the block holds no unfinished frame.
module radio_frame_checker_with_digest
    import rfc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    rfc_byte_if.sink            frame_in,
    rfc_result_if.source        result_out,
    rfc_cfg_if.sink             cfg
);

    // Total frame length and the counter's view of it; the count saturates at
    // 255, while the largest legal frame is HeaderLen plus MAX_PAYLOAD bytes.
    localparam int unsigned FrameLen  = HeaderLen + MAX_PAYLOAD;
    localparam logic [8:0]  FrameLenW = 9'(FrameLen);
    localparam logic [8:0]  HeaderW   = 9'(HeaderLen);

    // Configuration register.
    logic [31:0] expected_network_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Frame state.
    logic [7:0]  byte_count_reg,    byte_count_next;
    status_t     first_fault_reg,   first_fault_next;
    logic [7:0]  type_hold_reg,     type_hold_next;
    logic [31:0] network_shift_reg, network_shift_next;
    logic [31:0] session_hold_reg,  session_hold_next;
    logic [31:0] sequence_hold_reg, sequence_hold_next;
    logic [7:0]  length_hold_reg,   length_hold_next;
    logic [31:0] digest_acc_reg,    digest_acc_next;

    // Result register.
    logic        res_valid_reg;
    status_t     res_status_reg,  res_status_next;
    logic [7:0]  res_type_reg;
    logic [31:0] res_session_reg;
    logic [31:0] res_sequence_reg;
    logic [6:0]  res_length_reg;
    logic [31:0] res_digest_reg;

    logic        res_free;
    logic        proc_fire;
    logic        frame_done;
    logic [8:0]  frame_len;

    // The result slot is free when empty or being emptied this cycle. The
    // registered byte moves on unless it ends a frame and the slot is busy.
    assign res_free   = !res_valid_reg || result_out.ready;
    assign proc_fire  = in_valid_reg && (!in_last_reg || res_free);
    assign frame_done = proc_fire && in_last_reg;

    assign frame_in.ready = !in_valid_reg || proc_fire;
    assign cfg.ready      = 1'b1;

    assign result_out.valid         = res_valid_reg;
    assign result_out.status        = res_status_reg;
    assign result_out.frame_type    = res_type_reg;
    assign result_out.session_id    = res_session_reg;
    assign result_out.sequence_no   = res_sequence_reg;
    assign result_out.payload_bytes = res_length_reg;
    assign result_out.frame_digest  = res_digest_reg;

    // Frame state update for the byte in the input register.
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        first_fault_next   = first_fault_reg;
        type_hold_next     = type_hold_reg;
        network_shift_next = network_shift_reg;
        session_hold_next  = session_hold_reg;
        sequence_hold_next = sequence_hold_reg;
        length_hold_next   = length_hold_reg;
        digest_acc_next    = digest_acc_reg;

        if ({1'b0, byte_count_reg} >= FrameLenW) begin
            // Past the longest legal frame: the overrun overrides any fault.
            first_fault_next = ST_LONG;
        end
        else if ({1'b0, byte_count_reg} >= HeaderW) begin
            digest_acc_next = fnv_mix(digest_acc_reg, in_byte_reg);
        end
        else if (byte_count_reg == 8'd0) begin
            if (in_byte_reg != MagicByte0 && first_fault_reg == ST_OK) begin
                first_fault_next = ST_MAGIC;
            end
        end
        else if (byte_count_reg == 8'd1) begin
            if (in_byte_reg != MagicByte1 && first_fault_reg == ST_OK) begin
                first_fault_next = ST_MAGIC;
            end
        end
        else if (byte_count_reg == 8'd2) begin
            if (in_byte_reg != VersionByte && first_fault_reg == ST_OK) begin
                first_fault_next = ST_VERSION;
            end
        end
        else if (byte_count_reg == 8'd3) begin
            type_hold_next  = in_byte_reg;
            digest_acc_next = fnv_mix(digest_acc_reg, in_byte_reg);
        end
        else if (byte_count_reg <= 8'd7) begin
            network_shift_next = {network_shift_reg[23:0], in_byte_reg};
            if (byte_count_reg == 8'd7 && network_shift_next != expected_network_reg
                && first_fault_reg == ST_OK) begin
                first_fault_next = ST_NETWORK;
            end
        end
        else if (byte_count_reg <= 8'd11) begin
            session_hold_next = {session_hold_reg[23:0], in_byte_reg};
        end
        else if (byte_count_reg <= 8'd15) begin
            sequence_hold_next = {sequence_hold_reg[23:0], in_byte_reg};
        end
        else begin
            length_hold_next = in_byte_reg;
        end

        if (byte_count_reg != 8'hFF) begin
            byte_count_next = byte_count_reg + 8'd1;
        end
    end

    // Status of a frame ending on this byte, using the freshly updated state.
    assign frame_len = {1'b0, byte_count_reg} + 9'd1;

    always_comb
    begin
        if (frame_len < HeaderW) begin
            res_status_next = ST_SHORT;
        end
        else if (first_fault_next != ST_OK) begin
            res_status_next = first_fault_next;
        end
        else if ({1'b0, length_hold_next} != frame_len - HeaderW) begin
            res_status_next = ST_LENGTH;
        end
        else begin
            res_status_next = ST_OK;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expected_network_reg <= '0;
        end
        else if (cfg.valid && cfg.ready) begin
            expected_network_reg <= cfg.data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_in.ready) begin
            in_valid_reg <= frame_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready) begin
            in_byte_reg <= frame_in.frame_byte;
            in_last_reg <= frame_in.last;
        end
    end

    // Frame state: updated per byte, returned to its reset value after the
    // last byte of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg    <= '0;
            first_fault_reg   <= ST_OK;
            type_hold_reg     <= '0;
            network_shift_reg <= '0;
            session_hold_reg  <= '0;
            sequence_hold_reg <= '0;
            length_hold_reg   <= '0;
            digest_acc_reg    <= FnvBasis;
        end
        else if (frame_done) begin
            byte_count_reg    <= '0;
            first_fault_reg   <= ST_OK;
            type_hold_reg     <= '0;
            network_shift_reg <= '0;
            session_hold_reg  <= '0;
            sequence_hold_reg <= '0;
            length_hold_reg   <= '0;
            digest_acc_reg    <= FnvBasis;
        end
        else if (proc_fire) begin
            byte_count_reg    <= byte_count_next;
            first_fault_reg   <= first_fault_next;
            type_hold_reg     <= type_hold_next;
            network_shift_reg <= network_shift_next;
            session_hold_reg  <= session_hold_next;
            sequence_hold_reg <= sequence_hold_next;
            length_hold_reg   <= length_hold_next;
            digest_acc_reg    <= digest_acc_next;
        end
    end

    // Result register: loaded at the end of a frame, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (frame_done) begin
            res_valid_reg <= 1'b1;
        end
        else if (result_out.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done) begin
            res_status_reg <= res_status_next;
            if (res_status_next == ST_OK) begin
                res_type_reg     <= type_hold_next;
                res_session_reg  <= session_hold_next;
                res_sequence_reg <= sequence_hold_next;
                res_length_reg   <= length_hold_next[6:0];
                res_digest_reg   <= digest_acc_next;
            end
            else begin
                res_type_reg     <= '0;
                res_session_reg  <= '0;
                res_sequence_reg <= '0;
                res_length_reg   <= '0;
                res_digest_reg   <= '0;
            end
        end
    end

endmodule

// ===== src/rfc_checker.sv =====
// Port-level assertions for the radio frame checker, and the bind that
// attaches them to the top level. Depends on rfc_pkg.
`timescale 1ns / 1ps

module rfc_checker
    import rfc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  frame_type,
    input logic [31:0] session_id,
    input logic [31:0] sequence_no,
    input logic [6:0]  payload_bytes,
    input logic [31:0] frame_digest
);

    localparam logic [7:0] MaxPayloadW = 8'(MAX_PAYLOAD);

    // A result waiting to be taken keeps its value.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(frame_digest) && $stable(session_id))
        else $error("result changed while stalled");

    // A rejected frame reports nothing but its status.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> frame_type == '0 && session_id == '0
            && sequence_no == '0 && payload_bytes == '0 && frame_digest == '0)
        else $error("rejected frame carries non-zero fields");

    // An accepted frame never declares more payload than the block allows.
    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> {1'b0, payload_bytes} <= MaxPayloadW)
        else $error("accepted frame declares an oversized payload");

    // With the result slot empty nothing can hold up the byte stream.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

endmodule

bind radio_frame_checker_with_digest rfc_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_rfc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (frame_in.ready),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .status        (result_out.status),
    .frame_type    (result_out.frame_type),
    .session_id    (result_out.session_id),
    .sequence_no   (result_out.sequence_no),
    .payload_bytes (result_out.payload_bytes),
    .frame_digest  (result_out.frame_digest)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the radio frame checker with payload digest.
// Depends on rfc_pkg, the channel interfaces in rfc_if.sv and the block's top level.
`timescale 1ns / 1ps

// The bench streams frames into the block one byte per item and predicts every
// frame report in its own model of the header checks and the FNV-1a digest.
// Each report taken from the result channel is compared field by field with the
// oldest prediction. Both sides of the block idle at random, and one phase holds
// the result side off for a long stretch so that the block has to stall its
// input. The network register is rewritten between phases, only when no frame
// is in flight.
module testbench;
    import rfc_pkg::*;

    localparam int unsigned MaxPayload   = 64;
    localparam logic [31:0] FnvPrime     = 32'h0100_0193;
    localparam int unsigned MaxGap       = 14;
    localparam int unsigned StallCycles  = 200;
    // Settling time after the last report, before the register is touched or
    // the run is closed.
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned CycleLimit   = 400_000;
    localparam int unsigned MaxPrinted   = 60;

    // One frame report as it appears on the result channel.
    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_type;
        logic [31:0] session_id;
        logic [31:0] sequence_no;
        logic [6:0]  payload_bytes;
        logic [31:0] frame_digest;
    } frame_report_t;

    logic clk;
    logic rst_n;

    rfc_byte_if   frame_ch();
    rfc_result_if result_ch();
    rfc_cfg_if    cfg_ch();

    radio_frame_checker_with_digest #(
        .MAX_PAYLOAD(MaxPayload)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_in  (frame_ch),
        .result_out(result_ch),
        .cfg       (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame model: the bench's own copy of the register and frame state.
    // ------------------------------------------------------------------
    logic [31:0]   network_cfg;
    int unsigned   pos_count;
    status_t       fault_seen;
    logic [7:0]    type_byte;
    logic [31:0]   net_acc;
    logic [31:0]   session_acc;
    logic [31:0]   sequence_acc;
    int unsigned   declared_len;
    logic [31:0]   digest;

    // Reports that the model has predicted and the block has not yet given.
    frame_report_t expected_reports[$];

    // Bytes of the frame that the next call of send_frame will deliver.
    logic [7:0]    frame_buf[$];

    int unsigned   mismatches;
    int unsigned   bytes_sent;
    int unsigned   frames_sent;
    int unsigned   reports_checked;
    int unsigned   cfg_writes;
    int unsigned   status_hits[0:7];
    int unsigned   cycle_count;

    // Sender pacing: the gap before the next byte is drawn as each byte is taken.
    logic          tx_active;
    logic          tx_burst;
    logic          gaps_off;
    int unsigned   tx_next_gap;

    // Receiver pacing and the long hold-off, which the receiver counts itself.
    int unsigned   stall_order;
    int unsigned   stall_served;
    int unsigned   rx_hold;
    int unsigned   rx_wait;
    logic          rx_burst;

    function automatic logic [31:0] fnv_step(input logic [31:0] acc, input logic [7:0] value);
        return (acc ^ {24'd0, value}) * FnvPrime;
    endfunction

    function automatic void clear_frame_state();
        pos_count    = 0;
        fault_seen   = ST_OK;
        type_byte    = 8'd0;
        net_acc      = 32'd0;
        session_acc  = 32'd0;
        sequence_acc = 32'd0;
        declared_len = 0;
        digest       = FnvBasis;
    endfunction

    // Only the first header fault of a frame is kept.
    function automatic void record_fault(input status_t code);
        if (fault_seen == ST_OK)
        begin
            fault_seen = code;
        end
    endfunction

    // Advances the frame model by one accepted byte and, on the last byte of a
    // frame, queues the report that the block must give for it.
    function automatic void track_byte(input logic [7:0] value, input logic is_last);
        int unsigned   idx;
        int unsigned   len;
        frame_report_t report;
        idx = pos_count;
        if (idx >= HeaderLen + MaxPayload)
        begin
            // Past the longest legal frame the content no longer matters.
            fault_seen = ST_LONG;
        end
        else if (idx >= HeaderLen)
        begin
            digest = fnv_step(digest, value);
        end
        else
        begin
            case (idx)
                0: if (value != MagicByte0) record_fault(ST_MAGIC);
                1: if (value != MagicByte1) record_fault(ST_MAGIC);
                2: if (value != VersionByte) record_fault(ST_VERSION);
                3:
                begin
                    type_byte = value;
                    digest    = fnv_step(digest, value);
                end
                4, 5, 6, 7:
                begin
                    net_acc = {net_acc[23:0], value};
                    if (idx == 7 && net_acc != network_cfg)
                    begin
                        record_fault(ST_NETWORK);
                    end
                end
                8, 9, 10, 11:   session_acc  = {session_acc[23:0], value};
                12, 13, 14, 15: sequence_acc = {sequence_acc[23:0], value};
                default:        declared_len = 32'(value);
            endcase
        end
        if (pos_count < 255)
        begin
            pos_count = pos_count + 1;
        end
        if (is_last)
        begin
            len    = idx + 1;
            report = '0;
            if (len < HeaderLen)
            begin
                report.status = ST_SHORT;
            end
            else if (fault_seen != ST_OK)
            begin
                report.status = fault_seen;
            end
            else if (declared_len != len - HeaderLen)
            begin
                report.status = ST_LENGTH;
            end
            else
            begin
                // Only a clean frame reports its fields; a rejected one reports zeros.
                report.status        = ST_OK;
                report.frame_type    = type_byte;
                report.session_id    = session_acc;
                report.sequence_no   = sequence_acc;
                report.payload_bytes = 7'(declared_len);
                report.frame_digest  = digest;
            end
            expected_reports.push_back(report);
            clear_frame_state();
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches = mismatches + 1;
        if (mismatches <= MaxPrinted)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: paced receiver and the report checker.
    // ------------------------------------------------------------------

    // After each report the receiver waits a drawn pause before it is ready
    // again. A new stall order from the test sequence makes it hold ready low
    // while it counts rx_hold down from StallCycles itself.
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        int unsigned pause;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_wait         <= 0;
            rx_hold         <= 0;
            rx_burst        <= 1'b0;
            stall_served    <= 0;
        end
        else if (stall_served != stall_order)
        begin
            stall_served    <= stall_order;
            rx_hold         <= StallCycles;
            result_ch.ready <= 1'b0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold         <= rx_hold - 1;
            result_ch.ready <= 1'b0;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            // Now and then the receiver switches between paced and flat-out.
            if ($urandom_range(0, 15) == 0)
            begin
                rx_burst <= ~rx_burst;
            end
            pause           = rx_burst ? 0 : $urandom_range(0, MaxGap);
            rx_wait         <= pause;
            result_ch.ready <= (pause == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait         <= rx_wait - 1;
            result_ch.ready <= (rx_wait == 1);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Every report taken at a clock edge is checked against the oldest
    // prediction. Values are read as they stood before the edge.
    always @(posedge clk)
    begin : report_checker
        frame_report_t got;
        frame_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.status        = status_t'(result_ch.status);
            got.frame_type    = result_ch.frame_type;
            got.session_id    = result_ch.session_id;
            got.sequence_no   = result_ch.sequence_no;
            got.payload_bytes = result_ch.payload_bytes;
            got.frame_digest  = result_ch.frame_digest;
            reports_checked = reports_checked + 1;
            status_hits[result_ch.status] = status_hits[result_ch.status] + 1;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("report with status %0d but no frame outstanding",
                                          result_ch.status));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_ch.status, want.status));
                if (got.frame_type != want.frame_type)
                    report_mismatch($sformatf("frame_type %02h, expected %02h",
                                              got.frame_type, want.frame_type));
                if (got.session_id != want.session_id)
                    report_mismatch($sformatf("session_id %08h, expected %08h",
                                              got.session_id, want.session_id));
                if (got.sequence_no != want.sequence_no)
                    report_mismatch($sformatf("sequence_no %08h, expected %08h",
                                              got.sequence_no, want.sequence_no));
                if (got.payload_bytes != want.payload_bytes)
                    report_mismatch($sformatf("payload_bytes %0d, expected %0d",
                                              got.payload_bytes, want.payload_bytes));
                if (got.frame_digest != want.frame_digest)
                    report_mismatch($sformatf("frame_digest %08h, expected %08h",
                                              got.frame_digest, want.frame_digest));
            end
        end
    end

    // The run is abandoned if it goes on far longer than any correct run could.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("Run stopped at the cycle limit with %0d reports still outstanding.",
                     expected_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte side: sending items and building frames.
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is taken. Valid stays
    // high when the next byte follows at once, so it is never dropped and
    // raised again in the same step.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        repeat (tx_next_gap) @(posedge clk);
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= value;
        frame_ch.last       <= is_last;
        @(posedge clk);
        while (!frame_ch.ready)
        begin
            @(posedge clk);
        end
        track_byte(value, is_last);
        bytes_sent  = bytes_sent + 1;
        tx_active   = 1'b1;
        tx_next_gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
        if (tx_next_gap != 0)
        begin
            frame_ch.valid <= 1'b0;
        end
    endtask

    // Lowers valid in the step of the final handshake, unless a gap already did.
    task automatic stop_input();
        if (tx_active && tx_next_gap == 0)
        begin
            frame_ch.valid <= 1'b0;
        end
        tx_active = 1'b0;
    endtask

    task automatic send_frame();
        tx_burst = gaps_off || ($urandom_range(0, 3) == 0);
        foreach (frame_buf[i])
        begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent = frames_sent + 1;
    endtask

    // Waits until every predicted report has come back, then lets the block
    // settle, since a byte without last may still be on its way through.
    task automatic wait_idle();
        stop_input();
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_network(input logic [31:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        network_cfg  = value;
        cfg_writes   = cfg_writes + 1;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fills frame_buf with a well-formed 17-byte header.
    function automatic void start_frame(input logic [31:0] net, input logic [7:0] ftype,
                                        input logic [31:0] session, input logic [31:0] seq,
                                        input logic [7:0] declared);
        frame_buf.delete();
        frame_buf.push_back(MagicByte0);
        frame_buf.push_back(MagicByte1);
        frame_buf.push_back(VersionByte);
        frame_buf.push_back(ftype);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(net[8*k +: 8]);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(session[8*k +: 8]);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(seq[8*k +: 8]);
        frame_buf.push_back(declared);
    endfunction

    function automatic void add_payload(input int unsigned count);
        repeat (count) frame_buf.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // The register comes out of reset as zero, so a frame for network zero
    // must pass before anything has been written.
    task automatic test_reset_network();
        start_frame(32'd0, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 8'd2);
        add_payload(2);
        send_frame();
    endtask

    // Frames that end inside the header, including a single byte and one that
    // also has a bad magic, which must still be reported as too short.
    task automatic test_short_frames();
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        start_frame(network_cfg, 8'h5A, 32'h1234_5678, 32'h9ABC_DEF0, 8'd0);
        void'(frame_buf.pop_back());
        frame_buf[0] = 8'h00;
        send_frame();
    endtask

    // Each header check on its own, then pairs of faults to confirm that the
    // earlier check in the order wins.
    task automatic test_header_faults();
        start_frame(network_cfg, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        send_frame();
        start_frame(network_cfg, 8'h11, 32'h0, 32'h0, 8'd0);
        frame_buf[0] = 8'h00;
        send_frame();
        start_frame(network_cfg, 8'h11, 32'h0, 32'h0, 8'd1);
        add_payload(1);
        frame_buf[1] = 8'hFF;
        send_frame();
        start_frame(network_cfg, 8'h22, 32'h0, 32'h0, 8'd0);
        frame_buf[2] = 8'h02;
        send_frame();
        start_frame(network_cfg, 8'h33, 32'h0, 32'h0, 8'd0);
        frame_buf[7] = frame_buf[7] ^ 8'h01;
        send_frame();
        start_frame(network_cfg, 8'h33, 32'h0, 32'h0, 8'd0);
        frame_buf[4] = frame_buf[4] ^ 8'h80;
        send_frame();
        // Declared length disagrees with the payload, one way and the other.
        start_frame(network_cfg, 8'h44, 32'h0, 32'h0, 8'd5);
        add_payload(3);
        send_frame();
        start_frame(network_cfg, 8'h44, 32'h0, 32'h0, 8'h80);
        send_frame();
        // Bad magic beats bad version; bad version beats wrong network;
        // wrong network beats a length mismatch.
        start_frame(network_cfg, 8'h55, 32'h0, 32'h0, 8'd0);
        frame_buf[1] = 8'h00;
        frame_buf[2] = 8'h00;
        send_frame();
        start_frame(network_cfg ^ 32'h0000_0100, 8'h55, 32'h0, 32'h0, 8'd0);
        frame_buf[2] = 8'hFF;
        send_frame();
        start_frame(network_cfg ^ 32'h0100_0000, 8'h66, 32'h0, 32'h0, 8'd9);
        send_frame();
    endtask

    // The longest legal payload, one byte more with a bad magic as well (too
    // long wins), and a frame long enough to saturate the byte count. A clean
    // frame afterwards shows that the state was cleared.
    task automatic test_length_limits();
        start_frame(network_cfg, 8'h7E, 32'hDEAD_BEEF, 32'h0000_0001, 8'(MaxPayload));
        add_payload(MaxPayload);
        send_frame();
        start_frame(network_cfg, 8'h7E, 32'h1, 32'h2, 8'(MaxPayload));
        add_payload(MaxPayload + 1);
        frame_buf[0] = 8'h00;
        send_frame();
        start_frame(network_cfg, 8'h01, 32'h1, 32'h2, 8'hFF);
        add_payload(260 - HeaderLen);
        send_frame();
        start_frame(network_cfg, 8'h02, 32'hCAFE_F00D, 32'h0BAD_F00D, 8'd1);
        add_payload(1);
        send_frame();
    endtask

    // The register at all ones and at an uneven value, each with a matching and a wrong network.
    task automatic test_network_register();
        write_network(32'hFFFF_FFFF);
        start_frame(network_cfg, 8'hA5, 32'h0102_0304, 32'h0506_0708, 8'd4);
        add_payload(4);
        send_frame();
        start_frame(32'd0, 8'hA5, 32'h0, 32'h0, 8'd0);
        send_frame();
        write_network(32'h8000_0001);
        start_frame(network_cfg, 8'h3C, 32'h0, 32'h0, 8'd0);
        send_frame();
        start_frame(32'h0000_0001, 8'h3C, 32'h0, 32'h0, 8'd0);
        send_frame();
    endtask

    // The receiver holds off while the sender keeps offering one-byte frames
    // and two clean ones with no gaps, so the block must fill up and stall input.
    task automatic test_output_backpressure();
        wait_idle();
        stall_order <= stall_order + 1;
        gaps_off = 1'b1;
        repeat (12)
        begin
            frame_buf.delete();
            frame_buf.push_back(8'($urandom));
            send_frame();
        end
        start_frame(network_cfg, 8'($urandom), $urandom, $urandom, 8'd10);
        add_payload(10);
        send_frame();
        start_frame(network_cfg, 8'($urandom), $urandom, $urandom, 8'd0);
        send_frame();
        gaps_off = 1'b0;
        wait_idle();
    endtask

    // Mostly well-formed frames with random content and small payloads, some
    // with one deliberate defect, and some plain noise.
    task automatic random_frame();
        int unsigned pick;
        int unsigned plen;
        int unsigned cut;
        int unsigned spot;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8)
                                           : $urandom_range(0, MaxPayload);
        start_frame(network_cfg, 8'($urandom), $urandom, $urandom, 8'(plen));
        add_payload(plen);
        if (pick >= 85)
        begin
            frame_buf.delete();
            add_payload($urandom_range(1, 40));
        end
        else if (pick >= 70)
        begin
            case ($urandom_range(0, 5))
                0: frame_buf[$urandom_range(0, 1)] = 8'($urandom);
                1: frame_buf[2] = 8'($urandom);
                2:
                begin
                    spot = $urandom_range(4, 7);
                    frame_buf[spot] = frame_buf[spot] ^ (8'd1 << $urandom_range(0, 7));
                end
                3: frame_buf[16] = 8'($urandom);
                4: add_payload($urandom_range(MaxPayload - plen + 1, MaxPayload - plen + 16));
                default:
                begin
                    cut = $urandom_range(1, 16);
                    while (frame_buf.size() > cut)
                    begin
                        void'(frame_buf.pop_back());
                    end
                end
            endcase
        end
        send_frame();
    endtask

    // Three phases of random traffic, each under its own network value.
    task automatic test_random_traffic();
        int unsigned phase_start;
        int unsigned phase_frames;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       write_network($urandom);
                1:       write_network(32'd0);
                default: write_network(32'hFFFF_FFFF);
            endcase
            phase_start  = bytes_sent;
            phase_frames = 0;
            while (bytes_sent - phase_start < 40 || phase_frames < 3)
            begin
                random_frame();
                phase_frames = phase_frames + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= 8'd0;
        frame_ch.last       <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= 32'd0;
        rst_n               <= 1'b0;
        network_cfg     = 32'd0;
        mismatches      = 0;
        bytes_sent      = 0;
        frames_sent     = 0;
        reports_checked = 0;
        cfg_writes      = 0;
        cycle_count     = 0;
        stall_order     = 0;
        tx_active       = 1'b0;
        tx_burst        = 1'b0;
        gaps_off        = 1'b0;
        tx_next_gap     = 0;
        foreach (status_hits[s]) status_hits[s] = 0;
        clear_frame_state();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_network();
        test_short_frames();
        test_header_faults();
        test_length_limits();
        test_network_register();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d bytes in %0d frames, checked %0d reports, %0d network writes.",
                 bytes_sent, frames_sent, reports_checked, cfg_writes);
        $display("Reports ok/short/long/magic/version/network/length: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6]);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rfc_pkg.sv
src/rfc_if.sv
src/radio_frame_checker_with_digest.sv
src/rfc_checker.sv
tb/sv/testbench.sv
